### hdl/bct_pkg.sv
// shared constants, register indexes and types of the corner turner
package bct_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  localparam logic [CFG_IDX_W-1:0] CFG_TRANSPOSE_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_SIGNALS       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_CHANNELS      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_BLOCK = 2'd3;

  // transpose modes
  localparam logic MODE_SIG_TIME      = 1'b0;
  localparam logic MODE_SIG_CHAN_TIME = 1'b1;

  // dimension widths
  localparam int NS_W = 7;
  localparam int NC_W = 11;
  localparam int NT_W = 15;

  // read counter widths
  localparam int RSC_W = 6;
  localparam int RTC_W = 14;
  localparam int RCC_W = 10;

  // payload widths
  localparam int VALUE_W = 32;
  localparam int HALF_W  = 16;

  localparam logic [NS_W-1:0] NS_MAX   = 7'd64;
  localparam logic [NS_W-1:0] NS_RESET = 7'd2;
  localparam logic [NC_W-1:0] NC_MAX   = 11'd1024;
  localparam logic [NC_W-1:0] NC_RESET = 11'd1;
  localparam logic [NT_W-1:0] NT_MAX   = 15'd16384;
  localparam logic [NT_W-1:0] NT_RESET = 15'd8192;

  // depth of the operation queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // effective block geometry after clamping and fitting to a bank
  typedef struct packed {
    logic            mode;
    logic [NS_W-1:0] ns;
    logic [NC_W-1:0] nc;
    logic [NT_W-1:0] nt;
  } geom_t;

endpackage

### hdl/bct_if.sv
// valid/ready channel interfaces of the corner turner
interface bct_in_if;
  logic                        valid;
  logic                        ready;
  logic [bct_pkg::VALUE_W-1:0] sample_value;
  logic                        flush;

  modport source (output valid, output sample_value, output flush, input ready);
  modport sink (input valid, input sample_value, input flush, output ready);
endinterface

interface bct_out_if;
  logic                        valid;
  logic                        ready;
  logic [bct_pkg::VALUE_W-1:0] out_value;
  logic                        last_of_block;

  modport source (output valid, output out_value, output last_of_block, input ready);
  modport sink (input valid, input out_value, input last_of_block, output ready);
endinterface

### hdl/bct_geom.sv
// configuration registers and iterative block geometry unit
module bct_geom #(
  parameter int BANK_DEPTH = 16384,
  localparam int DW = $clog2(BANK_DEPTH + 1)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [bct_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bct_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output bct_pkg::geom_t                   geo,
  output logic                             geo_busy,
  output logic [DW-1:0]                    geo_len,
  output logic [DW-1:0]                    geo_stride
);

  localparam int CW     = $clog2(DW);
  localparam int SC_W   = bct_pkg::NS_W + bct_pkg::NC_W;
  localparam int LEN_PW = SC_W + bct_pkg::NT_W;
  localparam int ST_W   = bct_pkg::NC_W + bct_pkg::NT_W;
  localparam logic [DW-1:0] DIVIDEND = DW'(BANK_DEPTH);

  localparam logic [3:0] G_IDLE    = 4'd0;
  localparam logic [3:0] G_CLAMP   = 4'd1;
  localparam logic [3:0] G_SC      = 4'd2;
  localparam logic [3:0] G_SC_CHK  = 4'd3;
  localparam logic [3:0] G_DIV_C   = 4'd4;
  localparam logic [3:0] G_LEN     = 4'd5;
  localparam logic [3:0] G_LEN_CHK = 4'd6;
  localparam logic [3:0] G_DIV_T   = 4'd7;
  localparam logic [3:0] G_STRIDE  = 4'd8;

  logic                      mode_r;
  logic [bct_pkg::NS_W-1:0]  ns_cfg_r;
  logic [bct_pkg::NC_W-1:0]  nc_cfg_r;
  logic [bct_pkg::NT_W-1:0]  nt_cfg_r;

  logic [3:0]                state_r, state_nxt;
  logic [bct_pkg::NS_W-1:0]  s_r;
  logic [bct_pkg::NC_W-1:0]  c_r;
  logic [bct_pkg::NT_W-1:0]  t_r;
  logic [SC_W-1:0]           sc_r;
  logic [LEN_PW-1:0]         len_r;
  logic [ST_W-1:0]           stride_r;

  logic [DW-1:0]             den_r, rem_r, quo_r, rem_nxt, quo_nxt;
  logic [CW-1:0]             cnt_r;
  logic [DW:0]               rem_sh;
  logic                      rem_ge;
  logic                      sc_over, len_over;

  logic [bct_pkg::NS_W-1:0]  s_clamp;
  logic [bct_pkg::NC_W-1:0]  c_clamp;
  logic [bct_pkg::NT_W-1:0]  t_clamp;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= bct_pkg::MODE_SIG_TIME;
      ns_cfg_r <= bct_pkg::NS_RESET;
      nc_cfg_r <= bct_pkg::NC_RESET;
      nt_cfg_r <= bct_pkg::NT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        bct_pkg::CFG_TRANSPOSE_MODE:    mode_r   <= cfg_wdata[0];
        bct_pkg::CFG_NUM_SIGNALS:       ns_cfg_r <= cfg_wdata[bct_pkg::NS_W-1:0];
        bct_pkg::CFG_NUM_CHANNELS:      nc_cfg_r <= cfg_wdata[bct_pkg::NC_W-1:0];
        bct_pkg::CFG_SAMPLES_PER_BLOCK: nt_cfg_r <= cfg_wdata[bct_pkg::NT_W-1:0];
        default: ;
      endcase
    end
  end

  // zero acts as one, large values saturate; channels count as one in signal-time mode
  assign s_clamp = (ns_cfg_r == '0) ? bct_pkg::NS_W'(1) :
                   (ns_cfg_r > bct_pkg::NS_MAX) ? bct_pkg::NS_MAX : ns_cfg_r;
  assign c_clamp = (mode_r == bct_pkg::MODE_SIG_TIME) ? bct_pkg::NC_W'(1) :
                   (nc_cfg_r == '0) ? bct_pkg::NC_W'(1) :
                   (nc_cfg_r > bct_pkg::NC_MAX) ? bct_pkg::NC_MAX : nc_cfg_r;
  assign t_clamp = (nt_cfg_r == '0) ? bct_pkg::NT_W'(1) :
                   (nt_cfg_r > bct_pkg::NT_MAX) ? bct_pkg::NT_MAX : nt_cfg_r;

  assign sc_over  = LEN_PW'(sc_r) > LEN_PW'(BANK_DEPTH);
  assign len_over = len_r > LEN_PW'(BANK_DEPTH);

  // restoring divider step on the bank depth, msb first
  assign rem_sh  = {rem_r, DIVIDEND[cnt_r]};
  assign rem_ge  = rem_sh >= {1'b0, den_r};
  assign rem_nxt = rem_ge ? DW'(rem_sh - {1'b0, den_r}) : DW'(rem_sh);
  assign quo_nxt = {quo_r[DW-2:0], rem_ge};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      G_IDLE:    state_nxt = G_IDLE;
      G_CLAMP:   state_nxt = G_SC;
      G_SC:      state_nxt = G_SC_CHK;
      G_SC_CHK:  state_nxt = sc_over ? G_DIV_C : G_LEN;
      G_DIV_C:   state_nxt = (cnt_r == '0) ? G_SC : G_DIV_C;
      G_LEN:     state_nxt = G_LEN_CHK;
      G_LEN_CHK: state_nxt = len_over ? G_DIV_T : G_STRIDE;
      G_DIV_T:   state_nxt = (cnt_r == '0) ? G_LEN : G_DIV_T;
      G_STRIDE:  state_nxt = G_IDLE;
      default:   state_nxt = G_CLAMP;
    endcase
    if (cfg_wr_en) begin
      state_nxt = G_CLAMP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= G_CLAMP;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      G_CLAMP: begin
        s_r <= s_clamp;
        c_r <= c_clamp;
        t_r <= t_clamp;
      end
      G_SC: begin
        sc_r <= SC_W'(s_r) * SC_W'(c_r);
      end
      G_SC_CHK: begin
        den_r <= DW'(s_r);
        rem_r <= '0;
        quo_r <= '0;
        cnt_r <= CW'(DW - 1);
      end
      G_DIV_C: begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == '0) begin
          c_r <= bct_pkg::NC_W'(quo_nxt);
        end
      end
      G_LEN: begin
        len_r <= LEN_PW'(sc_r) * LEN_PW'(t_r);
      end
      G_LEN_CHK: begin
        den_r <= DW'(sc_r);
        rem_r <= '0;
        quo_r <= '0;
        cnt_r <= CW'(DW - 1);
      end
      G_DIV_T: begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == '0) begin
          t_r <= bct_pkg::NT_W'(quo_nxt);
        end
      end
      G_STRIDE: begin
        stride_r <= ST_W'(c_r) * ST_W'(t_r);
      end
      default: ;
    endcase
  end

  assign geo.mode   = mode_r;
  assign geo.ns     = s_r;
  assign geo.nc     = c_r;
  assign geo.nt     = t_r;
  assign geo_busy   = state_r != G_IDLE;
  assign geo_len    = DW'(len_r);
  assign geo_stride = DW'(stride_r);

`ifndef NO_ASSERTIONS
  a_geom_fits_bank: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == G_IDLE |-> len_r != '0 && len_r <= LEN_PW'(BANK_DEPTH) &&
                          LEN_PW'(stride_r) <= len_r)
    else $error("geometry does not fit one bank");
`endif

endmodule

### hdl/bct_front.sv
// front end: accepts items, steps the read and write counters, forms memory operations
module bct_front #(
  parameter int BANK_DEPTH = 16384,
  parameter int SAMPLE_BITS = 32,
  localparam int AW     = $clog2(BANK_DEPTH),
  localparam int DW     = $clog2(BANK_DEPTH + 1),
  localparam int MIW    = $clog2(2 * BANK_DEPTH),
  localparam int ELEM_W = (SAMPLE_BITS < 32) ? SAMPLE_BITS : 32,
  localparam int OP_W   = 3 + 2 * MIW + ELEM_W,
  localparam int FCW    = $clog2(bct_pkg::QUEUE_DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  bct_in_if.sink            in_ch,
  input  bct_pkg::geom_t    geo,
  input  logic              geo_busy,
  input  logic [DW-1:0]     geo_len,
  input  logic [DW-1:0]     geo_stride,
  input  logic [FCW-1:0]    fifo_count,
  output logic              push,
  output logic [OP_W-1:0]   push_data
);

  localparam int SP_W = bct_pkg::RSC_W + DW;
  localparam int CP_W = bct_pkg::RCC_W + bct_pkg::NT_W;

  logic                       held_r, held_nxt;
  logic [bct_pkg::RSC_W-1:0]  rsc_r, rsc_nxt;
  logic [bct_pkg::RTC_W-1:0]  rtc_r, rtc_nxt;
  logic [bct_pkg::RCC_W-1:0]  rcc_r, rcc_nxt;
  logic [AW-1:0]              wi_r, wi_nxt;
  logic                       wb_r, wb_nxt;

  logic                       acc, wr_en, blk_done, rd_last;
  logic                       s_end, t_end, c_end, c_in;
  logic [bct_pkg::RSC_W-1:0]  s_cur, ns_m1;
  logic [bct_pkg::RTC_W-1:0]  t_cur, nt_m1;
  logic [bct_pkg::RCC_W-1:0]  oc_cur, ic_cur, nc_m1;
  logic [SP_W-1:0]            sprod;
  logic [CP_W-1:0]            cprod;
  logic [bct_pkg::VALUE_W-1:0] wval;

  // operation stage
  logic                       st_valid_r;
  logic                       st_rd_r, st_last_r, st_rbank_r, st_wr_r;
  logic [AW-1:0]              st_sprod_r, st_cprod_r, st_t_r;
  logic [MIW-1:0]             st_widx_r;
  logic [ELEM_W-1:0]          st_wdata_r;
  logic [AW-1:0]              rd_addr;
  logic [MIW-1:0]             rd_idx;

  // room for the staged operation plus this one
  assign in_ch.ready = !geo_busy &&
                       ((FCW + 1)'(fifo_count) + (FCW + 1)'(st_valid_r) <
                        (FCW + 1)'(bct_pkg::QUEUE_DEPTH));
  assign acc = in_ch.valid && in_ch.ready;

  assign ns_m1 = bct_pkg::RSC_W'(geo.ns - bct_pkg::NS_W'(1));
  assign nt_m1 = bct_pkg::RTC_W'(geo.nt - bct_pkg::NT_W'(1));
  assign nc_m1 = bct_pkg::RCC_W'(geo.nc - bct_pkg::NC_W'(1));

  // counters past a shrunk limit read as at the limit
  assign s_cur  = ({1'b0, rsc_r} < geo.ns) ? rsc_r : ns_m1;
  assign t_cur  = ({1'b0, rtc_r} < geo.nt) ? rtc_r : nt_m1;
  assign c_in   = {1'b0, rcc_r} < geo.nc;
  assign oc_cur = c_in ? rcc_r : nc_m1;
  assign ic_cur = c_in ? nc_m1 - rcc_r : '0;

  assign s_end = s_cur == ns_m1;
  assign t_end = t_cur == nt_m1;
  assign c_end = oc_cur == nc_m1;
  assign rd_last = (geo.mode == bct_pkg::MODE_SIG_TIME) ? (s_end && t_end) :
                                                          (s_end && t_end && c_end);

  assign wr_en    = !in_ch.flush;
  assign blk_done = wr_en && (({1'b0, wi_r} + (AW + 1)'(1)) >= (AW + 1)'(geo_len));

  assign sprod = SP_W'(s_cur) * SP_W'(geo_stride);
  assign cprod = CP_W'(ic_cur) * CP_W'(geo.nt);

  assign wval = (geo.mode == bct_pkg::MODE_SIG_TIME) ?
                {{(bct_pkg::VALUE_W - bct_pkg::HALF_W){1'b0}},
                 in_ch.sample_value[bct_pkg::HALF_W-1:0]} :
                in_ch.sample_value;

  always_comb begin
    held_nxt = held_r;
    rsc_nxt  = rsc_r;
    rtc_nxt  = rtc_r;
    rcc_nxt  = rcc_r;
    wi_nxt   = wi_r;
    wb_nxt   = wb_r;
    if (acc) begin
      if (held_r) begin
        if (geo.mode == bct_pkg::MODE_SIG_TIME) begin
          if (s_end) begin
            rsc_nxt = '0;
            rtc_nxt = t_cur + bct_pkg::RTC_W'(1);
          end else begin
            rsc_nxt = s_cur + bct_pkg::RSC_W'(1);
          end
          rcc_nxt = '0;
        end else begin
          if (c_end) begin
            rcc_nxt = '0;
            if (t_end) begin
              rtc_nxt = '0;
              rsc_nxt = s_cur + bct_pkg::RSC_W'(1);
            end else begin
              rtc_nxt = t_cur + bct_pkg::RTC_W'(1);
            end
          end else begin
            rcc_nxt = oc_cur + bct_pkg::RCC_W'(1);
          end
        end
        if (rd_last) begin
          held_nxt = 1'b0;
          rsc_nxt  = '0;
          rtc_nxt  = '0;
          rcc_nxt  = '0;
        end
      end
      if (wr_en) begin
        if (blk_done) begin
          // swap banks, the just filled block becomes the held one
          wi_nxt   = '0;
          wb_nxt   = !wb_r;
          held_nxt = 1'b1;
          rsc_nxt  = '0;
          rtc_nxt  = '0;
          rcc_nxt  = '0;
        end else begin
          wi_nxt = wi_r + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r     <= 1'b0;
      rsc_r      <= '0;
      rtc_r      <= '0;
      rcc_r      <= '0;
      wi_r       <= '0;
      wb_r       <= 1'b0;
      st_valid_r <= 1'b0;
    end else begin
      held_r     <= held_nxt;
      rsc_r      <= rsc_nxt;
      rtc_r      <= rtc_nxt;
      rcc_r      <= rcc_nxt;
      wi_r       <= wi_nxt;
      wb_r       <= wb_nxt;
      st_valid_r <= acc && (held_r || wr_en);
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      st_rd_r    <= held_r;
      st_last_r  <= rd_last;
      st_rbank_r <= !wb_r;
      st_sprod_r <= AW'(sprod);
      st_cprod_r <= AW'(cprod);
      st_t_r     <= AW'(t_cur);
      st_wr_r    <= wr_en;
      st_widx_r  <= wb_r ? MIW'(wi_r) + MIW'(BANK_DEPTH) : MIW'(wi_r);
      st_wdata_r <= ELEM_W'(wval);
    end
  end

  // transposed address stays below the bank depth
  assign rd_addr = st_sprod_r + st_cprod_r + st_t_r;
  assign rd_idx  = st_rbank_r ? MIW'(rd_addr) + MIW'(BANK_DEPTH) : MIW'(rd_addr);

  assign push      = st_valid_r;
  assign push_data = {st_rd_r, rd_idx, st_last_r, st_wr_r, st_widx_r, st_wdata_r};

`ifndef NO_ASSERTIONS
  a_block_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    acc && blk_done |=> held_r && (wb_r != $past(wb_r)))
    else $error("completed block not taken as held block");
`endif

endmodule

### hdl/bct_fifo.sv
// short operation queue between front and back end
module bct_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data,
  output logic [CW-1:0]    count
);

  logic [WIDTH-1:0] entry_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_valid = count_r != '0;
  assign pop_data  = entry_r[rd_ptr_r];
  assign count     = count_r;

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> count_r < CW'(DEPTH))
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("pop from empty queue");
`endif

endmodule

### hdl/bct_back.sv
// back end: ping-pong sample memory and registered result stage
module bct_back #(
  parameter int BANK_DEPTH = 16384,
  parameter int SAMPLE_BITS = 32,
  localparam int MIW    = $clog2(2 * BANK_DEPTH),
  localparam int ELEM_W = (SAMPLE_BITS < 32) ? SAMPLE_BITS : 32,
  localparam int OP_W   = 3 + 2 * MIW + ELEM_W
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            op_valid,
  input  logic [OP_W-1:0] op_data,
  output logic            pop,
  bct_out_if.source       out_ch
);

  localparam int WIDX_LO = ELEM_W;
  localparam int WR_BIT  = ELEM_W + MIW;
  localparam int LAST_BIT = WR_BIT + 1;
  localparam int RIDX_LO = LAST_BIT + 1;
  localparam int RD_BIT  = OP_W - 1;

  logic [ELEM_W-1:0] sample_banks_r [2 * BANK_DEPTH];
  logic [ELEM_W-1:0] rdata_r;
  logic              out_last_r;
  logic              out_valid_r, out_valid_nxt;

  logic              op_rd, op_wr, op_last;
  logic [MIW-1:0]    op_ridx, op_widx;
  logic [ELEM_W-1:0] op_wdata;

  assign op_rd    = op_data[RD_BIT];
  assign op_ridx  = op_data[RIDX_LO +: MIW];
  assign op_last  = op_data[LAST_BIT];
  assign op_wr    = op_data[WR_BIT];
  assign op_widx  = op_data[WIDX_LO +: MIW];
  assign op_wdata = op_data[ELEM_W-1:0];

  // a read waits only for the result register to free up
  assign pop = op_valid && (!op_rd || !out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (pop && op_wr) begin
      sample_banks_r[op_widx] <= op_wdata;
    end
    if (pop && op_rd) begin
      rdata_r    <= sample_banks_r[op_ridx];
      out_last_r <= op_last;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop && op_rd) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.out_value     = bct_pkg::VALUE_W'(rdata_r);
  assign out_ch.last_of_block = out_last_r;

endmodule

### hdl/block_corner_turn_transposer.sv
// top level of the ping-pong corner turner
// usage:
//   in_ch carries one sample per transaction (sample_value, flush); out_ch carries
//   one transposed sample per transaction (out_value, last_of_block).
//   cfg_wr_en/cfg_index/cfg_wdata write the four geometry registers; write them
//   only while no transaction is in flight.
//   samples of a block are written linearly into one bank while the previous
//   block is read in transposed order from the other bank; a transaction yields
//   one result whenever a full block is held, a flush transaction writes nothing.
// timing:
//   one input transaction per cycle sustained while in_ch.ready stays high; a result
//   reaches the output register through the stage, queue and memory read registers.
//   the memory does one write and one read per cycle, which sets the rate.
//   after reset and after every configuration write the geometry unit runs its
//   clamp and multiply steps and at most two serial divides with in_ch.ready low.
// reset and stall:
//   reset clears the counters, the queue and the held block; bank contents
//   are not cleared. when the receiver stalls, the result register holds and
//   the 4-entry queue keeps taking input until it fills, then in_ch.ready drops.
module block_corner_turn_transposer #(
  parameter int BANK_DEPTH = 16384,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [bct_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bct_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  bct_in_if.sink                          in_ch,
  bct_out_if.source                       out_ch
);

  localparam int DW     = $clog2(BANK_DEPTH + 1);
  localparam int MIW    = $clog2(2 * BANK_DEPTH);
  localparam int ELEM_W = (SAMPLE_BITS < 32) ? SAMPLE_BITS : 32;
  // one memory operation: read, read index, last, write, write index, write data
  localparam int OP_W   = 3 + 2 * MIW + ELEM_W;
  localparam int FCW    = $clog2(bct_pkg::QUEUE_DEPTH + 1);

  bct_pkg::geom_t   geo;
  logic             geo_busy;
  logic [DW-1:0]    geo_len;
  logic [DW-1:0]    geo_stride;

  logic             push;
  logic [OP_W-1:0]  push_data;
  logic             pop;
  logic             op_valid;
  logic [OP_W-1:0]  op_data;
  logic [FCW-1:0]   fifo_count;

  // geometry: clamp the registers and fit the block into one bank
  bct_geom #(
    .BANK_DEPTH (BANK_DEPTH)
  ) u_geom (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .geo        (geo),
    .geo_busy   (geo_busy),
    .geo_len    (geo_len),
    .geo_stride (geo_stride)
  );

  // front: takes transactions and turns them into memory operations
  bct_front #(
    .BANK_DEPTH  (BANK_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .geo        (geo),
    .geo_busy   (geo_busy),
    .geo_len    (geo_len),
    .geo_stride (geo_stride),
    .fifo_count (fifo_count),
    .push       (push),
    .push_data  (push_data)
  );

  // queue keeps write and read order so a bank is never read before it is filled
  bct_fifo #(
    .WIDTH (OP_W),
    .DEPTH (bct_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_valid (op_valid),
    .pop_data  (op_data),
    .count     (fifo_count)
  );

  // back: bank memory and result register
  bct_back #(
    .BANK_DEPTH  (BANK_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_valid (op_valid),
    .op_data  (op_data),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

### tb/sv/tb_block_corner_turn_transposer.sv
// self-checking testbench of the ping-pong corner turner with its own shadow predictor
`timescale 1ns / 100ps
module tb_block_corner_turn_transposer;

  localparam int BANK_DEPTH    = 16384;
  localparam int CYCLE_LIMIT   = 3000000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TOTAL_ITEMS   = 1050;
  localparam int CALM_ITEMS    = 200;
  localparam int LEN_CAP       = 256;

  typedef struct {
    logic [bct_pkg::VALUE_W-1:0] value;
    logic                        is_last;
  } turned_sample_t;

  // shadow of the corner turner: notes accepted samples, predicts and checks turned samples
  class corner_turn_scoreboard;
    logic                        mode;
    logic [bct_pkg::NS_W-1:0]    num_sig;
    logic [bct_pkg::NC_W-1:0]    num_chan;
    logic [bct_pkg::NT_W-1:0]    num_time;
    bit   [bct_pkg::VALUE_W-1:0] bank_mem [2*BANK_DEPTH];
    int unsigned                 fill [2];
    logic [bct_pkg::NT_W-1:0]    wr_idx;
    logic                        wr_bank;
    logic [bct_pkg::RSC_W-1:0]   rd_sig;
    logic [bct_pkg::RTC_W-1:0]   rd_time;
    logic [bct_pkg::RCC_W-1:0]   rd_chan;
    logic                        held;
    turned_sample_t              turned_q [$];
    int unsigned                 errors;

    function new();
      mode     = bct_pkg::MODE_SIG_TIME;
      num_sig  = bct_pkg::NS_RESET;
      num_chan = bct_pkg::NC_RESET;
      num_time = bct_pkg::NT_RESET;
      fill[0]  = 0;
      fill[1]  = 0;
      wr_idx   = '0;
      wr_bank  = 1'b0;
      rd_sig   = '0;
      rd_time  = '0;
      rd_chan  = '0;
      held     = 1'b0;
      errors   = 0;
    endfunction

    function longint unsigned clamp_dim(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
    endfunction

    // effective dimensions: zero acts as one, saturate, then fit the block into a bank
    function void fit_block(input logic m, input logic [bct_pkg::NS_W-1:0] ns_r,
                            input logic [bct_pkg::NC_W-1:0] nc_r,
                            input logic [bct_pkg::NT_W-1:0] nt_r,
                            output int unsigned ns, output int unsigned nc,
                            output int unsigned nt);
      longint unsigned s, c, t;
      s = clamp_dim(ns_r, bct_pkg::NS_MAX);
      c = (m == bct_pkg::MODE_SIG_CHAN_TIME) ? clamp_dim(nc_r, bct_pkg::NC_MAX) : 1;
      t = clamp_dim(nt_r, bct_pkg::NT_MAX);
      if (s * c > BANK_DEPTH) c = BANK_DEPTH / s;
      if (c == 0) c = 1;
      if (s * c * t > BANK_DEPTH) t = BANK_DEPTH / (s * c);
      if (t == 0) t = 1;
      ns = int'(s);
      nc = int'(c);
      nt = int'(t);
    endfunction

    function int unsigned block_len(logic m, logic [bct_pkg::NS_W-1:0] ns_r,
                                    logic [bct_pkg::NC_W-1:0] nc_r,
                                    logic [bct_pkg::NT_W-1:0] nt_r);
      int unsigned s, c, t;
      fit_block(m, ns_r, nc_r, nt_r, s, c, t);
      return s * c * t;
    endfunction

    // a new geometry only reads entries already written in the held bank
    function bit read_safe(int unsigned new_len);
      return !held || new_len <= fill[int'(wr_bank ^ 1'b1)];
    endfunction

    function int unsigned pending();
      return turned_q.size();
    endfunction

    function void note_config(logic [bct_pkg::CFG_IDX_W-1:0] idx,
                              logic [bct_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        bct_pkg::CFG_TRANSPOSE_MODE:    mode     = data[0];
        bct_pkg::CFG_NUM_SIGNALS:       num_sig  = data[bct_pkg::NS_W-1:0];
        bct_pkg::CFG_NUM_CHANNELS:      num_chan = data[bct_pkg::NC_W-1:0];
        bct_pkg::CFG_SAMPLES_PER_BLOCK: num_time = data[bct_pkg::NT_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_sample(logic [bct_pkg::VALUE_W-1:0] value, logic flush);
      int unsigned                 ns, nc, nt, s, t, oc, ic, addr, rbank, len;
      logic                        is_last;
      logic [bct_pkg::VALUE_W-1:0] kept;
      turned_sample_t              exp_s;
      fit_block(mode, num_sig, num_chan, num_time, ns, nc, nt);
      if (held) begin
        s     = (rd_sig < ns) ? rd_sig : ns - 1;
        t     = (rd_time < nt) ? rd_time : nt - 1;
        rbank = int'(wr_bank ^ 1'b1);
        if (mode == bct_pkg::MODE_SIG_TIME) begin
          addr    = s * nt + t;
          is_last = (s == ns - 1) && (t == nt - 1);
          if (s == ns - 1) begin
            rd_sig  = '0;
            rd_time = bct_pkg::RTC_W'(t + 1);
          end else begin
            rd_sig = bct_pkg::RSC_W'(s + 1);
          end
          rd_chan = '0;
        end else begin
          // channels come out reversed; a channel past the limit reads channel 0
          oc      = (rd_chan < nc) ? rd_chan : nc - 1;
          ic      = (rd_chan < nc) ? nc - 1 - rd_chan : 0;
          addr    = s * nc * nt + ic * nt + t;
          is_last = (s == ns - 1) && (t == nt - 1) && (oc == nc - 1);
          if (oc == nc - 1) begin
            rd_chan = '0;
            if (t == nt - 1) begin
              rd_time = '0;
              rd_sig  = bct_pkg::RSC_W'(s + 1);
            end else begin
              rd_time = bct_pkg::RTC_W'(t + 1);
            end
          end else begin
            rd_chan = bct_pkg::RCC_W'(oc + 1);
          end
        end
        addr          = addr % BANK_DEPTH;
        exp_s.value   = bank_mem[rbank * BANK_DEPTH + addr];
        exp_s.is_last = is_last;
        turned_q.push_back(exp_s);
        if (is_last) begin
          held    = 1'b0;
          rd_sig  = '0;
          rd_time = '0;
          rd_chan = '0;
        end
      end
      if (!flush) begin
        len  = ns * nc * nt;
        kept = value;
        if (mode == bct_pkg::MODE_SIG_TIME) kept[bct_pkg::VALUE_W-1:bct_pkg::HALF_W] = '0;
        addr = wr_idx % BANK_DEPTH;
        bank_mem[int'(wr_bank) * BANK_DEPTH + addr] = kept;
        if (addr + 1 > fill[int'(wr_bank)]) fill[int'(wr_bank)] = addr + 1;
        if (wr_idx + 1 >= len) begin
          wr_idx  = '0;
          wr_bank = wr_bank ^ 1'b1;
          held    = 1'b1;
          rd_sig  = '0;
          rd_time = '0;
          rd_chan = '0;
        end else begin
          wr_idx = wr_idx + 1'b1;
        end
      end
    endfunction

    function void check_turned(logic [bct_pkg::VALUE_W-1:0] value, logic is_last);
      turned_sample_t exp_s;
      if (turned_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual out_value %h last_of_block %b",
                 $time, value, is_last);
        errors++;
        return;
      end
      exp_s = turned_q.pop_front();
      if (value !== exp_s.value) begin
        $display("%0t: out_value mismatch, expected %h, actual %h", $time, exp_s.value, value);
        errors++;
      end
      if (is_last !== exp_s.is_last) begin
        $display("%0t: last_of_block mismatch, expected %b, actual %b",
                 $time, exp_s.is_last, is_last);
        errors++;
      end
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           cfg_wr_en;
  logic [bct_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [bct_pkg::CFG_DATA_W-1:0] cfg_wdata;
  bit                             idle_on;
  int unsigned                    cycle_count;
  int unsigned                    sent_items;

  corner_turn_scoreboard sb = new();

  bct_in_if  in_ch ();
  bct_out_if out_ch ();

  block_corner_turn_transposer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog, far above the slowest legal run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_block_corner_turn_transposer: done, errors");
      $finish;
    end
  end

  // result side: check every accepted transaction, stall ready in random bursts
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        sb.check_turned(out_ch.out_value, out_ch.last_of_block);
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 14) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // random element, with all-ones and all-zeros now and then
  function automatic logic [bct_pkg::VALUE_W-1:0] sample_word();
    case ($urandom_range(0, 9))
      0:       return '1;
      1:       return '0;
      default: return $urandom;
    endcase
  endfunction

  // mostly small dimensions, sometimes zero, the saturation point, the register maximum or any register value
  function automatic int unsigned pick_dim(int unsigned common_hi, int unsigned sat,
                                           int unsigned reg_max);
    case ($urandom_range(0, 15))
      0:       return 0;
      1:       return sat;
      2:       return reg_max;
      3:       return $urandom_range(0, reg_max);
      default: return $urandom_range(1, common_hi);
    endcase
  endfunction

  // one input transaction, optionally preceded by an idle burst; called at a rising edge
  task automatic push_sample(input logic [bct_pkg::VALUE_W-1:0] value, input logic flush);
    // last stretch of the run goes without idling on either side
    if (sent_items + CALM_ITEMS >= TOTAL_ITEMS) idle_on = 1'b0;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.sample_value <= value;
    in_ch.flush        <= flush;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_sample(value, flush);
    sent_items++;
  endtask

  // hold the sender until every predicted result is out, then let the pipe empty
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bct_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bct_pkg::CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.note_config(idx, data);
  endtask

  task automatic load_geometry(input logic m, input int unsigned ns, input int unsigned nc,
                               input int unsigned nt);
    drain_results();
    write_reg(bct_pkg::CFG_TRANSPOSE_MODE, bct_pkg::CFG_DATA_W'(m));
    write_reg(bct_pkg::CFG_NUM_SIGNALS, bct_pkg::CFG_DATA_W'(ns));
    write_reg(bct_pkg::CFG_NUM_CHANNELS, bct_pkg::CFG_DATA_W'(nc));
    write_reg(bct_pkg::CFG_SAMPLES_PER_BLOCK, bct_pkg::CFG_DATA_W'(nt));
    cfg_wr_en <= 1'b0;
  endtask

  // complete the block being written, then flush the held block out
  task automatic close_block();
    while (sb.wr_idx != 0) push_sample(sample_word(), 1'b0);
    while (sb.held) push_sample($urandom, 1'b1);
  endtask

  initial begin : stimulus
    logic        m;
    logic        fl;
    int unsigned ns, nc, nt, len, n_items, flush_pct;

    idle_on            = 1'b0;
    sent_items         = 0;
    rst_n              <= 1'b0;
    cfg_wr_en          <= 1'b0;
    cfg_index          <= bct_pkg::CFG_TRANSPOSE_MODE;
    cfg_wdata          <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.sample_value <= '0;
    in_ch.flush        <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset geometry is a whole bank: a few samples only, no block completes
    push_sample('1, 1'b0);
    push_sample('0, 1'b0);
    push_sample(32'h1234_5678, 1'b0);

    // zero dimensions act as one; mode 0 keeps the low half only
    load_geometry(bct_pkg::MODE_SIG_TIME, 0, 0, 0);
    push_sample('1, 1'b0);
    push_sample(32'hA5A5_5A5A, 1'b0);
    push_sample('0, 1'b1);
    // nothing held any more: this flush is ignored
    push_sample('0, 1'b1);

    // signal-time to time-signal, two signals by three samples
    load_geometry(bct_pkg::MODE_SIG_TIME, 2, 1, 3);
    for (int i = 0; i < 12; i++) push_sample(32'hC0DE_0000 | i, 1'b0);
    close_block();

    // signal-channel-time with reversed channels, then a shrink while a block is held
    load_geometry(bct_pkg::MODE_SIG_CHAN_TIME, 2, 3, 2);
    for (int i = 0; i < 17; i++) push_sample(sample_word(), 1'b0);
    // read counters now sit past the new limits, write index past the new block end
    load_geometry(bct_pkg::MODE_SIG_CHAN_TIME, 1, 2, 2);
    for (int i = 0; i < 6; i++) push_sample(sample_word(), i[0]);
    close_block();

    // saturating registers: channels cut to 256, samples to one, the block stays open
    load_geometry(bct_pkg::MODE_SIG_CHAN_TIME, 127, 2047, 32767);
    idle_on = 1'b1;
    repeat (40) push_sample(sample_word(), 1'b0);
    // shrink below the write index: the open block closes on the next write
    load_geometry(bct_pkg::MODE_SIG_CHAN_TIME, 3, 2, 2);
    repeat (4) push_sample(sample_word(), 1'b0);
    // mode change under the held block, overrun drops the rest of it
    load_geometry(bct_pkg::MODE_SIG_TIME, 2, 1, 2);
    repeat (20) push_sample(sample_word(), 1'($urandom_range(0, 1)));

    // random geometries, clean or mid-block changes, random flush density
    while (sent_items < TOTAL_ITEMS) begin
      do begin
        m  = $urandom_range(0, 1) ? bct_pkg::MODE_SIG_CHAN_TIME : bct_pkg::MODE_SIG_TIME;
        ns = pick_dim(6, bct_pkg::NS_MAX, (1 << bct_pkg::NS_W) - 1);
        nc = pick_dim(4, bct_pkg::NC_MAX, (1 << bct_pkg::NC_W) - 1);
        nt = pick_dim(6, bct_pkg::NT_MAX, (1 << bct_pkg::NT_W) - 1);
        len = sb.block_len(m, bct_pkg::NS_W'(ns), bct_pkg::NC_W'(nc), bct_pkg::NT_W'(nt));
      end while (len > LEN_CAP);
      if (!sb.read_safe(len) || $urandom_range(0, 2) == 0) close_block();
      load_geometry(m, ns, nc, nt);
      idle_on   = (sent_items + CALM_ITEMS < TOTAL_ITEMS) && ($urandom_range(0, 3) != 0);
      n_items   = len * $urandom_range(1, 3) + $urandom_range(0, len);
      flush_pct = $urandom_range(0, 30);
      for (int k = 0; k < n_items && sent_items < TOTAL_ITEMS; k++) begin
        fl = ($urandom_range(0, 99) < flush_pct);
        push_sample(sample_word(), fl);
        if ($urandom_range(0, 63) == 0) drain_results();
      end
    end

    drain_results();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_block_corner_turn_transposer: done, clean");
    end else begin
      $display("tb_block_corner_turn_transposer: done, errors");
    end
    $finish;
  end

endmodule
